/* rtl/mpbm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpbm_pkg: shared types for the multi-pattern byte matcher
// Command codes, status codes, micro-ops and the controller/datapath links.
// ----------------------------------------------------------------------------
package mpbm_pkg;

   typedef enum logic [2:0] {
      OP_CLEAR = 3'd0,
      OP_ADD   = 3'd1,
      OP_BUILD = 3'd2,
      OP_START = 3'd3,
      OP_SCAN  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // datapath micro-ops, one per cycle
   typedef enum logic [4:0] {
      UOP_NONE,
      UOP_CAPTURE,
      UOP_CLR_REGS,
      UOP_CLR_SWEEP,
      UOP_ERR,
      UOP_ADD_RD,
      UOP_ADD_DEC,
      UOP_ADD_OUT,
      UOP_START,
      UOP_SCAN_RD,
      UOP_SCAN_STEP,
      UOP_SCAN_HIT,
      UOP_ROOT_INIT,
      UOP_ROOT_RD,
      UOP_ROOT_PUSH,
      UOP_Q_RD,
      UOP_Q_FAIL,
      UOP_Q_F,
      UOP_B_RD_S,
      UOP_B_RD_F,
      UOP_B_LINK,
      UOP_B_OUTC,
      UOP_B_OUTW,
      UOP_BUILD_DONE
   } uop_type;

   typedef struct packed {
      uop_type uop;
      logic    load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       add_bad;
      logic       scan_bad;
      logic       built;
      logic       goto_zero;
      logic       node_full;
      logic       last;
      logic       sweep_last;
      logic       b_last;
      logic       q_more;
      logic       c_zero;
   } dp_sts_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_DEC,
      S_SWEEP,
      S_ADD1,
      S_ADD2,
      S_SC1,
      S_SC2,
      S_R0,
      S_R1,
      S_Q0,
      S_Q1,
      S_Q2,
      S_B0,
      S_B1,
      S_B2,
      S_B3,
      S_B4,
      S_RESP
   } ctl_state_type;

endpackage
`default_nettype wire

/* rtl/multi_pattern_byte_matcher.sv */
`default_nettype none
// One command at a time: a scan byte passes through the decode, two dependent
//   reads (transition, then output memory) and the result load.
// Build: a pass over every symbol at the root, then one per queued node.
// Clear and reset: a sweep over every transition-table address zeroes the
//   transition, failure and output memories; after reset no beat is taken
//   until that sweep ends.
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher: multi-pattern byte matcher, top level
// Trie entry, failure-link build and byte scanning of an Aho-Corasick
// automaton, driven one command beat at a time.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher
   import mpbm_pkg::*;
#(
   parameter int NODES    = 256,
   parameter int PATTERNS = 32,
   parameter int ALPHABET = 256
)(
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_symbol,
   input  wire logic        req_last_of_pattern,
   input  wire logic [4:0]  req_pattern_index,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_scan_node,
   output logic [31:0]      rsp_hit_mask,
   output logic [31:0]      rsp_matched_mask,
   output logic [8:0]       rsp_node_total,
   output logic [7:0]       rsp_pattern_total,
   output logic             rsp_is_built
);

   // controller issues one micro-op per cycle; datapath reports flags back
   ctl_cmd_type cmd;
   dp_sts_type  sts;

   mpbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // memories: transition table (node x symbol), failure links, output
   // masks and the breadth-first queue; result beat is registered here too
   mpbm_dp #(
      .NODES    (NODES),
      .PATTERNS (PATTERNS),
      .ALPHABET (ALPHABET)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_opcode          (req_opcode),
      .req_symbol          (req_symbol),
      .req_last_of_pattern (req_last_of_pattern),
      .req_pattern_index   (req_pattern_index),
      .rsp_status          (rsp_status),
      .rsp_scan_node       (rsp_scan_node),
      .rsp_hit_mask        (rsp_hit_mask),
      .rsp_matched_mask    (rsp_matched_mask),
      .rsp_node_total      (rsp_node_total),
      .rsp_pattern_total   (rsp_pattern_total),
      .rsp_is_built        (rsp_is_built)
   );

endmodule
`default_nettype wire

/* rtl/mpbm_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpbm_ctrl: sequencer for the matcher
// Walks each command through its micro-ops and owns both handshakes.
// ----------------------------------------------------------------------------
module mpbm_ctrl
   import mpbm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ctl_cmd_type      cmd,
   input  wire dp_sts_type  sts
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.uop      = UOP_NONE;
      cmd.load_rsp = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         S_INIT: begin
            cmd.uop = UOP_CLR_SWEEP;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.uop  = UOP_CAPTURE;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (sts.op)
               OP_CLEAR: begin
                  cmd.uop  = UOP_CLR_REGS;
                  state_in = S_SWEEP;
               end
               OP_ADD: begin
                  if (sts.add_bad) begin
                     cmd.uop  = UOP_ERR;
                     state_in = S_RESP;
                  end else begin
                     cmd.uop  = UOP_ADD_RD;
                     state_in = S_ADD1;
                  end
               end
               OP_BUILD: begin
                  if (sts.built) begin
                     cmd.uop  = UOP_ERR;
                     state_in = S_RESP;
                  end else begin
                     cmd.uop  = UOP_ROOT_INIT;
                     state_in = S_R0;
                  end
               end
               OP_START: begin
                  cmd.uop  = sts.built ? UOP_START : UOP_ERR;
                  state_in = S_RESP;
               end
               OP_SCAN: begin
                  if (sts.scan_bad) begin
                     cmd.uop  = UOP_ERR;
                     state_in = S_RESP;
                  end else begin
                     cmd.uop  = UOP_SCAN_RD;
                     state_in = S_SC1;
                  end
               end
               default: begin
                  cmd.uop  = UOP_ERR;
                  state_in = S_RESP;
               end
            endcase
         end
         S_SWEEP: begin
            cmd.uop = UOP_CLR_SWEEP;
            if (sts.sweep_last) state_in = S_RESP;
         end
         S_ADD1: begin
            cmd.uop = UOP_ADD_DEC;
            if (sts.last && !(sts.goto_zero && sts.node_full)) state_in = S_ADD2;
            else state_in = S_RESP;
         end
         S_ADD2: begin
            cmd.uop  = UOP_ADD_OUT;
            state_in = S_RESP;
         end
         S_SC1: begin
            cmd.uop  = UOP_SCAN_STEP;
            state_in = S_SC2;
         end
         S_SC2: begin
            cmd.uop  = UOP_SCAN_HIT;
            state_in = S_RESP;
         end
         S_R0: begin
            cmd.uop  = UOP_ROOT_RD;
            state_in = S_R1;
         end
         S_R1: begin
            cmd.uop  = UOP_ROOT_PUSH;
            state_in = sts.b_last ? S_Q0 : S_R0;
         end
         S_Q0: begin
            if (sts.q_more) begin
               cmd.uop  = UOP_Q_RD;
               state_in = S_Q1;
            end else begin
               cmd.uop  = UOP_BUILD_DONE;
               state_in = S_RESP;
            end
         end
         S_Q1: begin
            cmd.uop  = UOP_Q_FAIL;
            state_in = S_Q2;
         end
         S_Q2: begin
            cmd.uop  = UOP_Q_F;
            state_in = S_B0;
         end
         S_B0: begin
            cmd.uop  = UOP_B_RD_S;
            state_in = S_B1;
         end
         S_B1: begin
            cmd.uop  = UOP_B_RD_F;
            state_in = S_B2;
         end
         S_B2: begin
            cmd.uop = UOP_B_LINK;
            if (!sts.c_zero) state_in = S_B3;
            else state_in = sts.b_last ? S_Q0 : S_B0;
         end
         S_B3: begin
            cmd.uop  = UOP_B_OUTC;
            state_in = S_B4;
         end
         S_B4: begin
            cmd.uop  = UOP_B_OUTW;
            state_in = sts.b_last ? S_Q0 : S_B0;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_DEC))
      else $error("accepted beat not decoded");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("stalled result dropped");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("result raised outside response state");

endmodule
`default_nettype wire

/* rtl/mpbm_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpbm_dp: matcher datapath
// Transition, failure, output and queue memories plus scalar state.
// ----------------------------------------------------------------------------
module mpbm_dp
   import mpbm_pkg::*;
#(
   parameter int NODES    = 256,
   parameter int PATTERNS = 32,
   parameter int ALPHABET = 256
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctl_cmd_type cmd,
   output dp_sts_type       sts,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_symbol,
   input  wire logic        req_last_of_pattern,
   input  wire logic [4:0]  req_pattern_index,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_scan_node,
   output logic [31:0]      rsp_hit_mask,
   output logic [31:0]      rsp_matched_mask,
   output logic [8:0]       rsp_node_total,
   output logic [7:0]       rsp_pattern_total,
   output logic             rsp_is_built
);

   localparam int NW     = $clog2(NODES);
   localparam int SW     = $clog2(ALPHABET);
   localparam int AW     = NW + SW;
   localparam int NDEPTH = 1 << NW;
   localparam int GDEPTH = 1 << AW;

   // memories
   logic [NW-1:0]       goto_mem [GDEPTH];
   logic [NW-1:0]       fail_mem [NDEPTH];
   logic [PATTERNS-1:0] out_mem  [NDEPTH];
   logic [NW-1:0]       q_mem    [NDEPTH];

   logic [NW-1:0]       goto_rd_ff, fail_rd_ff, q_rd_ff;
   logic [PATTERNS-1:0] out_rd_ff;

   logic                goto_we, fail_we, out_we, q_we;
   logic [AW-1:0]       goto_waddr, goto_raddr;
   logic [NW-1:0]       goto_wdata;
   logic [NW-1:0]       fail_waddr, fail_raddr, fail_wdata;
   logic [NW-1:0]       out_waddr, out_raddr;
   logic [PATTERNS-1:0] out_wdata;
   logic [NW-1:0]       q_waddr, q_raddr, q_wdata;

   // latched command
   logic [2:0]  op_ff, op_in;
   logic [7:0]  sym_ff, sym_in;
   logic        last_ff, last_in;
   logic [4:0]  pidx_ff, pidx_in;

   // automaton state
   logic [NW:0]         nodes_ff, nodes_in;
   logic [7:0]          patterns_ff, patterns_in;
   logic                built_ff, built_in;
   logic [NW-1:0]       cursor_ff, cursor_in;
   logic [NW-1:0]       cur_ff, cur_in;
   logic [PATTERNS-1:0] seen_ff, seen_in;
   logic [PATTERNS-1:0] hit_ff, hit_in;
   status_type          status_ff, status_in;

   // build and sweep working registers
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [SW-1:0]       b_ff, b_in;
   logic [NW:0]         head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0]       s_ff, s_in, f_ff, f_in, c_ff, c_in, nxt_ff, nxt_in;
   logic [PATTERNS-1:0] outvia_ff, outvia_in;

   // result registers
   logic [1:0]  rsp_status_ff;
   logic [7:0]  rsp_scan_node_ff;
   logic [31:0] rsp_hit_ff, rsp_matched_ff;
   logic [8:0]  rsp_nodes_ff;
   logic [7:0]  rsp_patterns_ff;
   logic        rsp_built_ff;

   logic                sym_bad, pidx_bad, goto_zero, node_full, tail_ok, b_last;
   logic [SW-1:0]       sym_idx, b_next;
   logic [NW-1:0]       nxt;
   logic [PATTERNS-1:0] pbit;

   logic [NW+7:0]       cur_ext;
   logic [NW+9:0]       nodes_ext;
   logic [PATTERNS+31:0] hit_ext, seen_ext;

   assign sym_bad   = {1'b0, sym_ff} >= 9'(ALPHABET);
   assign pidx_bad  = {2'b0, pidx_ff} >= 7'(PATTERNS);
   assign goto_zero = goto_rd_ff == '0;
   assign node_full = nodes_ff >= (NW+1)'(NODES);
   assign tail_ok   = tail_ff < (NW+1)'(NODES);
   assign b_last    = b_ff == SW'(ALPHABET - 1);
   assign b_next    = b_last ? '0 : b_ff + SW'(1);
   assign sym_idx   = sym_ff[SW-1:0];
   assign nxt       = goto_zero ? nodes_ff[NW-1:0] : goto_rd_ff;
   assign pbit      = PATTERNS'(1) << pidx_ff;

   always_comb begin
      sts.op         = op_ff;
      sts.add_bad    = built_ff | sym_bad | (last_ff & pidx_bad);
      sts.scan_bad   = ~built_ff | sym_bad;
      sts.built      = built_ff;
      sts.goto_zero  = goto_zero;
      sts.node_full  = node_full;
      sts.last       = last_ff;
      sts.sweep_last = &clr_addr_ff;
      sts.b_last     = b_last;
      sts.q_more     = head_ff < tail_ff;
      sts.c_zero     = c_ff == '0;
   end

   always_comb begin
      op_in       = op_ff;
      sym_in      = sym_ff;
      last_in     = last_ff;
      pidx_in     = pidx_ff;
      nodes_in    = nodes_ff;
      patterns_in = patterns_ff;
      built_in    = built_ff;
      cursor_in   = cursor_ff;
      cur_in      = cur_ff;
      seen_in     = seen_ff;
      hit_in      = hit_ff;
      status_in   = status_ff;
      clr_addr_in = clr_addr_ff;
      b_in        = b_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      s_in        = s_ff;
      f_in        = f_ff;
      c_in        = c_ff;
      nxt_in      = nxt_ff;
      outvia_in   = outvia_ff;
      goto_we     = 1'b0;
      goto_waddr  = '0;
      goto_wdata  = '0;
      goto_raddr  = '0;
      fail_we     = 1'b0;
      fail_waddr  = '0;
      fail_wdata  = '0;
      fail_raddr  = '0;
      out_we      = 1'b0;
      out_waddr   = '0;
      out_wdata   = '0;
      out_raddr   = '0;
      q_we        = 1'b0;
      q_waddr     = '0;
      q_wdata     = '0;
      q_raddr     = '0;
      case (cmd.uop)
         UOP_CAPTURE: begin
            op_in     = req_opcode;
            sym_in    = req_symbol;
            last_in   = req_last_of_pattern;
            pidx_in   = req_pattern_index;
            status_in = ST_OK;
            hit_in    = '0;
         end
         UOP_CLR_REGS: begin
            nodes_in    = (NW+1)'(1);
            patterns_in = '0;
            built_in    = 1'b0;
            cursor_in   = '0;
            cur_in      = '0;
            seen_in     = '0;
            clr_addr_in = '0;
         end
         UOP_CLR_SWEEP: begin
            goto_we     = 1'b1;
            goto_waddr  = clr_addr_ff;
            fail_we     = 1'b1;
            fail_waddr  = clr_addr_ff[AW-1:SW];
            out_we      = 1'b1;
            out_waddr   = clr_addr_ff[AW-1:SW];
            clr_addr_in = clr_addr_ff + AW'(1);
         end
         UOP_ERR: status_in = ST_BAD;
         UOP_ADD_RD: goto_raddr = {cursor_ff, sym_idx};
         UOP_ADD_DEC: begin
            if (goto_zero && node_full) begin
               status_in = ST_FULL;
            end else begin
               if (goto_zero) begin
                  nodes_in   = nodes_ff + (NW+1)'(1);
                  goto_we    = 1'b1;
                  goto_waddr = {cursor_ff, sym_idx};
                  goto_wdata = nxt;
               end
               nxt_in    = nxt;
               out_raddr = nxt;
               if (last_ff) begin
                  cursor_in = '0;
                  if (patterns_ff != 8'hFF) patterns_in = patterns_ff + 8'd1;
               end else begin
                  cursor_in = nxt;
               end
            end
         end
         UOP_ADD_OUT: begin
            out_we    = 1'b1;
            out_waddr = nxt_ff;
            out_wdata = out_rd_ff | pbit;
         end
         UOP_START: begin
            cur_in  = '0;
            seen_in = '0;
         end
         UOP_SCAN_RD: goto_raddr = {cur_ff, sym_idx};
         UOP_SCAN_STEP: begin
            cur_in    = goto_rd_ff;
            out_raddr = goto_rd_ff;
         end
         UOP_SCAN_HIT: begin
            hit_in  = out_rd_ff;
            seen_in = seen_ff | out_rd_ff;
         end
         UOP_ROOT_INIT: begin
            b_in    = '0;
            head_in = '0;
            tail_in = '0;
         end
         UOP_ROOT_RD: goto_raddr = {NW'(0), b_ff};
         UOP_ROOT_PUSH: begin
            if (!goto_zero && tail_ok) begin
               q_we    = 1'b1;
               q_waddr = tail_ff[NW-1:0];
               q_wdata = goto_rd_ff;
               tail_in = tail_ff + (NW+1)'(1);
            end
            b_in = b_next;
         end
         UOP_Q_RD: begin
            q_raddr = head_ff[NW-1:0];
            head_in = head_ff + (NW+1)'(1);
         end
         UOP_Q_FAIL: begin
            s_in       = q_rd_ff;
            fail_raddr = q_rd_ff;
         end
         UOP_Q_F: f_in = fail_rd_ff;
         UOP_B_RD_S: goto_raddr = {s_ff, b_ff};
         UOP_B_RD_F: begin
            c_in       = goto_rd_ff;
            goto_raddr = {f_ff, b_ff};
         end
         UOP_B_LINK: begin
            if (c_ff == '0) begin
               // missing edge: borrow the failure node's transition
               goto_we    = 1'b1;
               goto_waddr = {s_ff, b_ff};
               goto_wdata = goto_rd_ff;
               b_in       = b_next;
            end else begin
               fail_we    = 1'b1;
               fail_waddr = c_ff;
               fail_wdata = goto_rd_ff;
               out_raddr  = goto_rd_ff;
               if (tail_ok) begin
                  q_we    = 1'b1;
                  q_waddr = tail_ff[NW-1:0];
                  q_wdata = c_ff;
                  tail_in = tail_ff + (NW+1)'(1);
               end
            end
         end
         UOP_B_OUTC: begin
            outvia_in = out_rd_ff;
            out_raddr = c_ff;
         end
         UOP_B_OUTW: begin
            out_we    = 1'b1;
            out_waddr = c_ff;
            out_wdata = out_rd_ff | outvia_ff;
            b_in      = b_next;
         end
         UOP_BUILD_DONE: begin
            built_in  = 1'b1;
            cursor_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (goto_we) goto_mem[goto_waddr] <= goto_wdata;
      goto_rd_ff <= goto_mem[goto_raddr];
      if (fail_we) fail_mem[fail_waddr] <= fail_wdata;
      fail_rd_ff <= fail_mem[fail_raddr];
      if (out_we) out_mem[out_waddr] <= out_wdata;
      out_rd_ff <= out_mem[out_raddr];
      if (q_we) q_mem[q_waddr] <= q_wdata;
      q_rd_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff    <= (NW+1)'(1);
         patterns_ff <= '0;
         built_ff    <= 1'b0;
         cursor_ff   <= '0;
         cur_ff      <= '0;
         seen_ff     <= '0;
         clr_addr_ff <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         b_ff        <= '0;
      end else begin
         nodes_ff    <= nodes_in;
         patterns_ff <= patterns_in;
         built_ff    <= built_in;
         cursor_ff   <= cursor_in;
         cur_ff      <= cur_in;
         seen_ff     <= seen_in;
         clr_addr_ff <= clr_addr_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         b_ff        <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      sym_ff    <= sym_in;
      last_ff   <= last_in;
      pidx_ff   <= pidx_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      s_ff      <= s_in;
      f_ff      <= f_in;
      c_ff      <= c_in;
      nxt_ff    <= nxt_in;
      outvia_ff <= outvia_in;
   end

   assign cur_ext   = {8'b0, cur_ff};
   assign nodes_ext = {9'b0, nodes_ff};
   assign hit_ext   = {32'b0, hit_ff};
   assign seen_ext  = {32'b0, seen_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff    <= status_ff;
         rsp_scan_node_ff <= cur_ext[7:0];
         rsp_hit_ff       <= hit_ext[31:0];
         rsp_matched_ff   <= seen_ext[31:0];
         rsp_nodes_ff     <= nodes_ext[8:0];
         rsp_patterns_ff  <= patterns_ff;
         rsp_built_ff     <= built_ff;
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_scan_node     = rsp_scan_node_ff;
   assign rsp_hit_mask      = rsp_hit_ff;
   assign rsp_matched_mask  = rsp_matched_ff;
   assign rsp_node_total    = rsp_nodes_ff;
   assign rsp_pattern_total = rsp_patterns_ff;
   assign rsp_is_built      = rsp_built_ff;

   a_scan_node_in_use: assert property (@(posedge clock) disable iff (reset)
      built_ff |-> ({1'b0, cur_ff} < nodes_ff))
      else $error("scan node beyond allocated nodes");

   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= tail_ff) && (tail_ff <= (NW+1)'(NODES)))
      else $error("breadth-first queue pointers out of order");

   a_node_count: assert property (@(posedge clock) disable iff (reset)
      (nodes_ff != '0) && (nodes_ff <= (NW+1)'(NODES)))
      else $error("node count out of range");

endmodule
`default_nettype wire

/* tb/multi_pattern_byte_matcher_tb.sv */
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher_tb: self-checking bench for the byte matcher
// A directed table covers the wrong-phase commands, the extreme bytes and
// indexes, a build with a pattern left open, and clear. Random phases then
// load small pattern sets, build and scan. A final phase fills the node store.
// A built-in trie model predicts every result beat that a row does not type in.
// ----------------------------------------------------------------------------
module multi_pattern_byte_matcher_tb
   import mpbm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // opcodes the block must refuse
   localparam logic [2:0] OP_UNUSED_5 = 3'd5;
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;
   localparam int CYCLE_LIMIT = 6_000_000;
   localparam int NODE_CAP    = 256;
   localparam int PRESSURE_AT = 300;   // result count at which rsp holds off
   localparam int PRESSURE_LEN = 400;  // cycles of that hold

   typedef struct packed {
      status_type  status;
      logic [7:0]  node;
      logic [31:0] hit;
      logic [31:0] seen;
      logic [8:0]  node_total;
      logic [7:0]  pat_total;
      logic        built;
   } match_rsp_type;

   typedef struct {
      logic [2:0] op;
      logic [7:0] sym;
      logic       last;
      logic [4:0] idx;
      logic       known;   // expectation typed into the row
      match_rsp_type want;
   } cmd_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = OP_CLEAR;
   logic [7:0]  req_symbol = '0;
   logic        req_last_of_pattern = 1'b0;
   logic [4:0]  req_pattern_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_scan_node;
   logic [31:0] rsp_hit_mask;
   logic [31:0] rsp_matched_mask;
   logic [8:0]  rsp_node_total;
   logic [7:0]  rsp_pattern_total;
   logic        rsp_is_built;

   multi_pattern_byte_matcher dut (.*);

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Trie model: transition table, failure links, per-node hit masks
   // ---------------------------------------------------------------------
   logic [7:0]  trans [0:65535];
   logic [7:0]  fail_of [0:255];
   logic [31:0] hits_of [0:255];
   int          nodes_in_use;
   int          pats_in_use;
   logic        links_built;
   logic [7:0]  insert_at;
   logic [7:0]  scan_at;
   logic [31:0] seen_acc;

   match_rsp_type pending_rsp [$];
   int          errors = 0;
   int          beats_sent = 0;
   int          rsp_seen = 0;
   int          full_hits = 0;
   int          bad_hits = 0;
   int          cycles = 0;
   logic        idle_on = 1'b1;
   int          hold_left = 0;

   function automatic void clear_trie();
      for (int i = 0; i < 65536; i++) trans[i] = '0;
      for (int i = 0; i < 256; i++) begin
         fail_of[i] = '0;
         hits_of[i] = '0;
      end
      nodes_in_use = 1;
      pats_in_use = 0;
      links_built = 1'b0;
      insert_at = '0;
      scan_at = '0;
      seen_acc = '0;
   endfunction

   // breadth-first walk: fail links, completed transitions, merged masks
   function automatic void link_trie();
      int         walk [$];
      int         s;
      int         f;
      logic [7:0] c;
      logic [7:0] via;
      for (int b = 0; b < 256; b++) begin
         c = trans[b];
         if (c != 0) begin
            fail_of[c] = '0;
            walk.insert(walk.size(), c);
         end
      end
      while (walk.size() != 0) begin
         s = walk.pop_front();
         f = fail_of[s];
         for (int b = 0; b < 256; b++) begin
            c = trans[s * 256 + b];
            via = trans[f * 256 + b];
            if (c == 0) begin
               trans[s * 256 + b] = via;
            end else begin
               fail_of[c] = via;
               hits_of[c] |= hits_of[via];
               walk.insert(walk.size(), c);
            end
         end
      end
   endfunction

   function automatic match_rsp_type predict_match(logic [2:0] op, logic [7:0] sym,
                                                   logic last, logic [4:0] idx);
      match_rsp_type r;
      logic [7:0] nxt;
      int         k;
      r.status = ST_OK;
      r.hit = '0;
      case (op)
         OP_CLEAR: clear_trie();
         OP_ADD: begin
            if (links_built) begin
               r.status = ST_BAD;
            end else begin
               k = insert_at * 256 + sym;
               nxt = trans[k];
               if (nxt == 0) begin
                  if (nodes_in_use >= NODE_CAP) begin
                     r.status = ST_FULL;
                  end else begin
                     nxt = nodes_in_use[7:0];
                     nodes_in_use++;
                     trans[k] = nxt;
                  end
               end
               if (r.status == ST_OK) begin
                  if (last) begin
                     hits_of[nxt] |= 32'd1 << idx;
                     if (pats_in_use < 255) pats_in_use++;
                     insert_at = '0;
                  end else begin
                     insert_at = nxt;
                  end
               end
            end
         end
         OP_BUILD: begin
            if (links_built) begin
               r.status = ST_BAD;
            end else begin
               link_trie();
               links_built = 1'b1;
               insert_at = '0;
            end
         end
         OP_START: begin
            if (!links_built) begin
               r.status = ST_BAD;
            end else begin
               scan_at = '0;
               seen_acc = '0;
            end
         end
         OP_SCAN: begin
            if (!links_built) begin
               r.status = ST_BAD;
            end else begin
               scan_at = trans[scan_at * 256 + sym];
               r.hit = hits_of[scan_at];
               seen_acc |= r.hit;
            end
         end
         default: r.status = ST_BAD;
      endcase
      r.node = scan_at;
      r.seen = seen_acc;
      r.node_total = nodes_in_use[8:0];
      r.pat_total = pats_in_use[7:0];
      r.built = links_built;
      return r;
   endfunction

   function automatic match_rsp_type mk(status_type st, logic [7:0] node,
                                        logic [31:0] hit, logic [31:0] seen,
                                        logic [8:0] nt, logic [7:0] pt, logic built);
      match_rsp_type r;
      r = '{st, node, hit, seen, nt, pt, built};
      return r;
   endfunction

   task automatic report(string field, longint want, longint got);
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
               $realtime, field, want, got);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // Command side: random gap while idle gaps are on, then hold the beat until it is taken
   // ---------------------------------------------------------------------
   task automatic send_cmd(logic [2:0] op, logic [7:0] sym, logic last, logic [4:0] idx,
                           logic known = 1'b0, match_rsp_type want = '0);
      int            gap;
      match_rsp_type p;
      gap = idle_on ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_symbol <= sym;
      req_last_of_pattern <= last;
      req_pattern_index <= idx;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      p = predict_match(op, sym, last, idx);
      if (p.status == ST_FULL) full_hits++;
      if (p.status == ST_BAD) bad_hits++;
      pending_rsp.insert(pending_rsp.size(), known ? want : p);
   endtask

   // ---------------------------------------------------------------------
   // Result side: per-beat stall count; one long hold-off so that the block
   // backs up and stalls the command side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_stall <= 1'b1;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else if (rsp_valid && !rsp_stall) begin
         n = (rsp_seen + 1 == PRESSURE_AT) ? PRESSURE_LEN
           : (idle_on ? $urandom_range(0, 16) : 0);
         hold_left <= n;
         rsp_stall <= (n != 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      match_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen <= rsp_seen + 1;
         if (pending_rsp.size() == 0) begin
            report("unexpected beat", 0, 1);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status) report("status", e.status, rsp_status);
            if (rsp_scan_node !== e.node) report("scan_node", e.node, rsp_scan_node);
            if (rsp_hit_mask !== e.hit) report("hit_mask", e.hit, rsp_hit_mask);
            if (rsp_matched_mask !== e.seen) report("matched_mask", e.seen, rsp_matched_mask);
            if (rsp_node_total !== e.node_total)
               report("node_total", e.node_total, rsp_node_total);
            if (rsp_pattern_total !== e.pat_total)
               report("pattern_total", e.pat_total, rsp_pattern_total);
            if (rsp_is_built !== e.built) report("is_built", e.built, rsp_is_built);
         end
      end
   end

   // watchdog; the clear sweep and the builds dominate the run time
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_rsp.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   cmd_row_type directed [$];
   logic [7:0] sym_pool [4];

   function automatic void add_row(cmd_row_type row);
      directed.insert(directed.size(), row);
   endfunction

   function automatic logic [7:0] pick_sym();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                         : sym_pool[$urandom_range(0, 3)];
   endfunction

   initial begin
      int npat;
      int len;
      int r;
      clear_trie();

      // after reset: everything refused except add, clear and build
      add_row('{OP_SCAN, 8'hFF, 1'b0, 5'd0, 1'b1, mk(ST_BAD, 0, 0, 0, 1, 0, 0)});
      add_row('{OP_START, 8'h00, 1'b0, 5'd0, 1'b1, mk(ST_BAD, 0, 0, 0, 1, 0, 0)});
      add_row('{OP_UNUSED_5, 8'h00, 1'b1, 5'd31, 1'b1, mk(ST_BAD, 0, 0, 0, 1, 0, 0)});
      add_row('{OP_UNUSED_6, 8'hAA, 1'b0, 5'd0, 1'b1, mk(ST_BAD, 0, 0, 0, 1, 0, 0)});
      add_row('{OP_UNUSED_7, 8'h55, 1'b0, 5'd0, 1'b1, mk(ST_BAD, 0, 0, 0, 1, 0, 0)});
      // patterns "00 FF" -> 31 and "FF" -> 0, extremes of byte and index
      add_row('{OP_ADD, 8'h00, 1'b0, 5'd31, 1'b1, mk(ST_OK, 0, 0, 0, 2, 0, 0)});
      add_row('{OP_ADD, 8'hFF, 1'b1, 5'd31, 1'b1, mk(ST_OK, 0, 0, 0, 3, 1, 0)});
      add_row('{OP_ADD, 8'hFF, 1'b1, 5'd0, 1'b1, mk(ST_OK, 0, 0, 0, 4, 2, 0)});
      // pattern "41 42" left open, then build mid-pattern
      add_row('{OP_ADD, 8'h41, 1'b0, 5'd0, 1'b1, mk(ST_OK, 0, 0, 0, 5, 2, 0)});
      add_row('{OP_ADD, 8'h42, 1'b0, 5'd7, 1'b0, '0});
      add_row('{OP_BUILD, 8'h00, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_BUILD, 8'h00, 1'b0, 5'd0, 1'b0, '0});      // twice
      add_row('{OP_ADD, 8'h12, 1'b1, 5'd3, 1'b0, '0});        // after build
      add_row('{OP_START, 8'h00, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_SCAN, 8'h00, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_SCAN, 8'hFF, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_SCAN, 8'hFF, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_SCAN, 8'h41, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_SCAN, 8'h42, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_START, 8'h00, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_SCAN, 8'h7E, 1'b0, 5'd0, 1'b0, '0});
      add_row('{OP_CLEAR, 8'h00, 1'b0, 5'd0, 1'b1, mk(ST_OK, 0, 0, 0, 1, 0, 0)});
      add_row('{OP_SCAN, 8'hFF, 1'b0, 5'd0, 1'b1, mk(ST_BAD, 0, 0, 0, 1, 0, 0)});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_cmd(directed[i].op, directed[i].sym, directed[i].last, directed[i].idx,
                  directed[i].known, directed[i].want);

      // random phases: small pattern sets over a few hot bytes, build, scan
      for (int ph = 0; ph < 5; ph++) begin
         idle_on = (ph != 2);
         send_cmd(OP_CLEAR, 8'($urandom), 1'($urandom), 5'($urandom));
         foreach (sym_pool[j]) sym_pool[j] = 8'($urandom_range(0, 255));
         npat = $urandom_range(1, 8);
         for (int p = 0; p < npat; p++) begin
            len = $urandom_range(1, (ph == 3) ? 12 : 5);
            for (int j = 0; j < len; j++) begin
               if ($urandom_range(0, 19) == 0)   // refused before build
                  send_cmd(($urandom_range(0, 1) != 0) ? OP_SCAN : OP_START,
                           8'($urandom), 1'($urandom), 5'($urandom));
               send_cmd(OP_ADD, pick_sym(), j == len - 1, 5'($urandom));
            end
         end
         if (ph == 4)   // open pattern at build time
            repeat (3) send_cmd(OP_ADD, pick_sym(), 1'b0, 5'($urandom));
         send_cmd(OP_BUILD, 8'($urandom), 1'($urandom), 5'($urandom));
         for (int i = 0; i < 260; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
               send_cmd(OP_ADD, pick_sym(), 1'($urandom), 5'($urandom));
            else if (r < 3)
               send_cmd(OP_BUILD, 8'($urandom), 1'($urandom), 5'($urandom));
            else if (r < 5)
               send_cmd(3'($urandom_range(OP_UNUSED_5, OP_UNUSED_7)), 8'($urandom),
                        1'($urandom), 5'($urandom));
            else if (r < 10)
               send_cmd(OP_START, 8'($urandom), 1'($urandom), 5'($urandom));
            else
               send_cmd(OP_SCAN, pick_sym(), 1'($urandom), 5'($urandom));
         end
      end

      // node store: one long chain fills it, further adds are refused
      idle_on = 1'b1;
      send_cmd(OP_CLEAR, 8'h00, 1'b0, 5'd0);
      for (int i = 0; i < 262; i++)
         send_cmd(OP_ADD, 8'($urandom), i >= 260, 5'($urandom));
      send_cmd(OP_SCAN, 8'($urandom), 1'b0, 5'd0);

      @(posedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d command beats, %0d results; %0d store-full and %0d refused commands",
               beats_sent, rsp_seen, full_hits, bad_hits);
      $display("covered reset, clear, trie entry, builds incl. mid-pattern, scans, stalls");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/mpbm_pkg.sv
rtl/mpbm_ctrl.sv
rtl/mpbm_dp.sv
rtl/multi_pattern_byte_matcher.sv
tb/multi_pattern_byte_matcher_tb.sv
